### hdl/huffman_table_encoder_defines.svh
// Assertion macros shared by the encoder RTL.
// No dependencies; included by the top level.
`ifndef HUFFMAN_TABLE_ENCODER_DEFINES_SVH
`define HUFFMAN_TABLE_ENCODER_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during rst.
`define HTE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during rst.
`define HTE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/hte_pkg.sv
// Shared constants, opcodes and types of the Huffman table encoder.
// No dependencies; imported by every module of the block.
package hte_pkg;

  localparam int MAX_CODE_LEN = 32;
  localparam int TABLE_DEPTH  = 256;
  localparam int SYM_W        = 8;
  localparam int CODE_W       = 32;
  localparam int LEN_W        = 6;
  localparam int BYTE_W       = 8;
  localparam int WORK_W       = CODE_W + BYTE_W;
  localparam int AVAIL_W      = 6;
  localparam int LEN_LIMIT    = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QIDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ENCODE = 2'd1;
  localparam logic [1:0] OP_FLUSH  = 2'd2;

  // Table entry: code left-aligned (first bit in MSB) plus its length.
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } table_entry_t;

  // Work handed from front to back.
  typedef struct packed {
    logic              is_flush;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } q_entry_t;

  typedef struct packed {
    logic stage_full;
  } front_status_t;

  typedef struct packed {
    logic               busy;
    logic [AVAIL_W-1:0] avail;
  } back_status_t;

endpackage

### hdl/hte_front.sv
// Front end: accepts items, owns the code table, classifies and queues work.
// Depends on hte_pkg.
module hte_front import hte_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          op,
  input  logic [SYM_W-1:0]    symbol,
  input  logic [CODE_W-1:0]   code_bits,
  input  logic [LEN_W-1:0]    code_length,
  output logic                push_valid,
  input  logic                push_ready,
  output q_entry_t            push_data,
  output front_status_t       status
);

  table_entry_t             code_mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]   entry_valid;
  table_entry_t             rd_entry;
  logic                     rd_hit;
  logic                     s1_valid;
  logic                     s1_flush;
  logic                     s1_push;
  logic                     s1_go;
  logic                     accept;
  logic [LEN_W-1:0]         len_sat;
  table_entry_t             wr_entry;

  assign accept = in_valid && in_ready;

  // Saturate the length and left-align the code; high junk bits fall off.
  assign len_sat = (code_length > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT) : code_length;
  always_comb begin
    wr_entry.code = code_bits << (LEN_W'(CODE_W) - len_sat);
    wr_entry.len  = len_sat;
  end

  // Table write and registered read.
  always_ff @(posedge clk) begin
    if (accept && op == OP_LOAD) begin
      code_mem[symbol] <= wr_entry;
    end
    if (accept && op == OP_ENCODE) begin
      rd_entry <= code_mem[symbol];
    end
  end

  // Entry valid bits: an entry never loaded reads as length zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      rd_hit      <= 1'b0;
    end else if (accept) begin
      if (op == OP_LOAD) begin
        entry_valid[symbol] <= 1'b1;
      end
      if (op == OP_ENCODE) begin
        rd_hit <= entry_valid[symbol];
      end
    end
  end

  // Drop encodes of empty entries; everything else in stage 1 is queued.
  assign s1_push = s1_flush || (rd_hit && rd_entry.len != '0);
  assign s1_go   = !s1_push || push_ready;
  assign in_ready = !s1_valid || s1_go;

  assign push_valid     = s1_valid && s1_push;
  assign push_data.is_flush = s1_flush;
  assign push_data.code = rd_entry.code;
  assign push_data.len  = rd_entry.len;

  // Load stage 1 with an encode or flush, else advance it when it drains.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_flush <= 1'b0;
    end else if (accept && (op == OP_ENCODE || op == OP_FLUSH)) begin
      s1_valid <= 1'b1;
      s1_flush <= (op == OP_FLUSH);
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  assign status.stage_full = s1_valid;

endmodule

### hdl/hte_fifo.sv
// Short queue of work entries between front and back.
// Depends on hte_pkg.
module hte_fifo import hte_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  q_entry_t          push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output q_entry_t          pop_data,
  output logic [QCNT_W-1:0] count
);

  q_entry_t          slots [QUEUE_DEPTH];
  logic [QIDX_W-1:0] wr_ptr;
  logic [QIDX_W-1:0] rd_ptr;
  logic              do_push;
  logic              do_pop;

  assign push_ready = count != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Store the pushed transaction.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### hdl/hte_back.sv
// Back end: merges codes into the pending bits and emits one byte per cycle
// while the output is not stalled. Depends on hte_pkg.
module hte_back import hte_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  q_entry_t           pop_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [BYTE_W-1:0]  out_byte,
  output logic               last,
  output back_status_t       status
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t              state;
  state_t              state_next;
  logic [WORK_W-1:0]   work;
  logic [WORK_W-1:0]   work_next;
  logic [AVAIL_W-1:0]  avail;
  logic [AVAIL_W-1:0]  avail_next;
  logic                flushing;
  logic                do_pop;
  logic                emit;
  logic [WORK_W-1:0]   merged;
  logic [AVAIL_W-1:0]  total;
  logic [AVAIL_W-1:0]  avail_after;

  assign pop_ready = state == ST_IDLE;
  assign do_pop    = pop_valid && pop_ready;
  assign emit      = (state == ST_RUN) && (!out_valid || out_ready);

  // Place the new code right behind the pending bits.
  assign merged = {work[WORK_W-1 -: BYTE_W], {CODE_W{1'b0}}}
                | ({pop_data.code, {BYTE_W{1'b0}}} >> avail[2:0]);
  assign total  = avail + pop_data.len;
  assign avail_after = (avail >= AVAIL_W'(BYTE_W)) ? avail - AVAIL_W'(BYTE_W) : '0;

  // Next state of the shifter.
  always_comb begin
    state_next = state;
    work_next  = work;
    avail_next = avail;
    unique case (state)
      ST_IDLE: begin
        if (do_pop) begin
          if (pop_data.is_flush) begin
            if (avail != '0) begin
              state_next = ST_RUN;
            end
          end else begin
            work_next  = merged;
            avail_next = total;
            if (total >= AVAIL_W'(BYTE_W)) begin
              state_next = ST_RUN;
            end
          end
        end
      end
      ST_RUN: begin
        if (emit) begin
          work_next  = work << BYTE_W;
          avail_next = avail_after;
          if (avail_after < AVAIL_W'(BYTE_W)) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Shifter registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      work     <= '0;
      avail    <= '0;
      flushing <= 1'b0;
    end else begin
      state <= state_next;
      work  <= work_next;
      avail <= avail_next;
      if (do_pop) begin
        flushing <= pop_data.is_flush;
      end
    end
  end

  // Output register: load on emit, drop when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte <= work[WORK_W-1 -: BYTE_W];
      last     <= flushing || (avail < AVAIL_W'(2 * BYTE_W));
    end
  end

  assign status.busy  = state == ST_RUN;
  assign status.avail = avail;

endmodule

### hdl/huffman_table_encoder.sv
// Top level of the table-driven Huffman encoder.
// Depends on hte_pkg, hte_front, hte_fifo, hte_back and the defines header.
//
//  channel | signals                                      | role
//  --------+----------------------------------------------+---------------------
//  in      | in_valid in_ready op symbol code_bits        | load / encode / flush
//          | code_length                                  |
//  out     | out_valid out_ready out_byte last            | packed code bytes
//
// A load is written at the table write port. An encode or flush passes stage 1
// and the queue before it reaches the back end; the back end then emits one
// byte per cycle while the output is not stalled, up to 4 bytes per encode.
// Reset clears the table valid bits at once, no clearing pass.
// A stalled output holds the back end; the two-entry queue lets the front
// keep accepting until it fills.
`include "huffman_table_encoder_defines.svh"

module huffman_table_encoder import hte_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         op,
  input  logic [SYM_W-1:0]   symbol,
  input  logic [CODE_W-1:0]  code_bits,
  input  logic [LEN_W-1:0]   code_length,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [BYTE_W-1:0]  out_byte,
  output logic               last
);

  logic              push_valid;
  logic              push_ready;
  q_entry_t          push_data;
  logic              pop_valid;
  logic              pop_ready;
  q_entry_t          pop_data;
  logic [QCNT_W-1:0] q_count;
  front_status_t     front_status;
  back_status_t      back_status;

  hte_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .symbol      (symbol),
    .code_bits   (code_bits),
    .code_length (code_length),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_data   (push_data),
    .status      (front_status)
  );

  hte_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .count      (q_count)
  );

  hte_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .last      (last),
    .status    (back_status)
  );

  // Idle back end holds less than a byte of pending bits.
  `HTE_ASSERT_NOW(a_idle_partial, !back_status.busy, back_status.avail < AVAIL_W'(BYTE_W), "back end idle with a full byte pending")
  // Input stalls only behind a full front stage that cannot drain.
  `HTE_ASSERT_NOW(a_stall_cause, !in_ready, front_status.stage_full && q_count == QCNT_W'(QUEUE_DEPTH), "input stalled without a blocked front stage")
  // The queue never exceeds its depth.
  `HTE_ASSERT_NOW(a_queue_bound, 1'b1, q_count <= QCNT_W'(QUEUE_DEPTH), "queue count beyond depth")
  // The back end keeps emitting while at least two bytes are pending.
  `HTE_ASSERT_NEXT(a_run_blocks, back_status.busy && back_status.avail >= AVAIL_W'(2 * BYTE_W), back_status.busy, "back end left emission early")

endmodule

### sim/huffman_byte_checker.sv
// Checker for the Huffman table encoder: predicts each coded byte and compares.
// Depends on hte_pkg; instantiated by the testbench top next to the encoder.
module huffman_byte_checker import hte_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [1:0]        op,
  input  logic [SYM_W-1:0]  symbol,
  input  logic [CODE_W-1:0] code_bits,
  input  logic [LEN_W-1:0]  code_length,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [BYTE_W-1:0] out_byte,
  input  logic              last,
  output int                fail_count,
  output int                bytes_due,
  output int                bytes_checked
);

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } coded_byte_t;

  // Expected bytes, oldest first
  coded_byte_t coded_bytes_due[$];
  coded_byte_t head;

  // Shadow of the code table and the bit packer
  logic [CODE_W-1:0] shadow_code [TABLE_DEPTH];
  logic [LEN_W-1:0]  shadow_len  [TABLE_DEPTH];
  logic [BYTE_W-1:0] pend_byte;
  logic [2:0]        fill_pos;

  task automatic report_mismatch(input string msg);
    $display("[%0t] checker: %s", $time, msg);
    fail_count++;
  endtask

  // Apply one accepted transaction to the shadow state and queue its bytes
  task automatic pack_code_bits(input logic [1:0] kind, input logic [SYM_W-1:0] sym,
                                input logic [CODE_W-1:0] bits,
                                input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0]  n;
    logic [CODE_W-1:0] word;
    int                emitted;
    emitted = 0;
    case (kind)
      OP_LOAD: begin
        // saturate the length, keep only the valid low bits
        n = (len > LEN_LIMIT) ? LEN_W'(LEN_LIMIT) : len;
        shadow_code[sym] = bits & ~({CODE_W{1'b1}} << n);
        shadow_len[sym]  = n;
      end
      OP_ENCODE: begin
        n    = shadow_len[sym];
        word = shadow_code[sym];
        for (int i = n; i > 0; i--) begin
          pend_byte[fill_pos] = pend_byte[fill_pos] | word[i-1];
          if (fill_pos == 3'd0) begin
            coded_bytes_due.push_back('{data: pend_byte, last: 1'b0});
            emitted++;
            pend_byte = '0;
            fill_pos  = 3'd7;
          end else begin
            fill_pos = fill_pos - 3'd1;
          end
        end
      end
      OP_FLUSH: begin
        if (fill_pos != 3'd7) begin
          coded_bytes_due.push_back('{data: pend_byte, last: 1'b0});
          emitted++;
          pend_byte = '0;
          fill_pos  = 3'd7;
        end
      end
      default: begin
      end
    endcase
    // mark the final byte of this transaction
    if (emitted > 0) coded_bytes_due[coded_bytes_due.size()-1].last = 1'b1;
  endtask

  // Track input transactions, then compare output transactions in order
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        shadow_code[i] = '0;
        shadow_len[i]  = '0;
      end
      pend_byte = '0;
      fill_pos  = 3'd7;
      coded_bytes_due.delete();
      fail_count    = 0;
      bytes_checked = 0;
      bytes_due    <= 0;
    end else begin
      if (in_valid && in_ready) pack_code_bits(op, symbol, code_bits, code_length);
      if (out_valid && out_ready) begin
        if (coded_bytes_due.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h last %b", out_byte, last));
        end else begin
          head = coded_bytes_due.pop_front();
          if (out_byte !== head.data)
            report_mismatch($sformatf("byte %0d: out_byte %02h, want %02h",
                                      bytes_checked, out_byte, head.data));
          if (last !== head.last)
            report_mismatch($sformatf("byte %0d: last %b, want %b",
                                      bytes_checked, last, head.last));
          bytes_checked++;
        end
      end
      bytes_due <= coded_bytes_due.size();
    end
  end

endmodule

### sim/testbench.sv
// Top of the Huffman table encoder testbench: clock, reset, stimulus, verdict.
// Depends on hte_pkg, huffman_table_encoder and huffman_byte_checker.
module testbench;
  import hte_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int POOL_SIZE     = 32;
  localparam int RANDOM_ITEMS  = 400;
  localparam int HOLD_AT       = 120;
  localparam int DRAIN_AT      = 280;
  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 200000;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        op;
  logic [SYM_W-1:0]  symbol;
  logic [CODE_W-1:0] code_bits;
  logic [LEN_W-1:0]  code_length;
  logic              out_valid;
  logic              out_ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last;
  logic              hold_req;

  int fail_count;
  int bytes_due;
  int bytes_checked;
  int burst_left;
  int n_load, n_encode, n_flush, n_unused;

  huffman_table_encoder dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .symbol      (symbol),
    .code_bits   (code_bits),
    .code_length (code_length),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .last        (last)
  );

  huffman_byte_checker byte_check (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .op            (op),
    .symbol        (symbol),
    .code_bits     (code_bits),
    .code_length   (code_length),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .last          (last),
    .fail_count    (fail_count),
    .bytes_due     (bytes_due),
    .bytes_checked (bytes_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hold valid and payload until the transaction is taken
  task automatic send_item(input logic [1:0] o, input logic [SYM_W-1:0] s,
                           input logic [CODE_W-1:0] b, input logic [LEN_W-1:0] l);
    in_valid    <= 1'b1;
    op          <= o;
    symbol      <= s;
    code_bits   <= b;
    code_length <= l;
    do @(posedge clk); while (!in_ready);
    case (o)
      OP_LOAD:   n_load++;
      OP_ENCODE: n_encode++;
      OP_FLUSH:  n_flush++;
      default:   n_unused++;
    endcase
  endtask

  // Send in bursts with random gaps between them
  task automatic offer(input logic [1:0] o, input logic [SYM_W-1:0] s,
                       input logic [CODE_W-1:0] b, input logic [LEN_W-1:0] l);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                : $urandom_range(1, 12);
    end
    send_item(o, s, b, l);
    burst_left--;
  endtask

  // Stop offering until every predicted byte has come out
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (bytes_due != 0);
    burst_left = 0;
  endtask

  // Mostly pool symbols so encodes hit loaded entries; loads vary the length
  task automatic random_item();
    int                r;
    int                k;
    logic [SYM_W-1:0]  s;
    logic [LEN_W-1:0]  l;
    r = $urandom_range(0, 99);
    s = ($urandom_range(0, 3) == 0) ? SYM_W'($urandom)
                                     : SYM_W'($urandom_range(0, POOL_SIZE - 1));
    if (r < 15) begin
      k = $urandom_range(0, 9);
      if (k == 0)      l = '0;
      else if (k == 1) l = LEN_W'($urandom_range(33, 63));
      else if (k == 2) l = LEN_W'(32);
      else             l = LEN_W'($urandom_range(1, 16));
      offer(OP_LOAD, s, $urandom, l);
    end else if (r < 80) begin
      offer(OP_ENCODE, s, $urandom, LEN_W'($urandom));
    end else if (r < 93) begin
      offer(OP_FLUSH, s, $urandom, LEN_W'($urandom));
    end else begin
      offer(OP_UNUSED, s, $urandom, LEN_W'($urandom));
    end
  endtask

  // Receiver: ready pattern changes per span; one long hold-off on request
  initial begin : receiver
    int   span;
    int   ready_pct;
    logic hold_taken;
    span       = 0;
    ready_pct  = 100;
    hold_taken = 1'b0;
    out_ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        if (span == 0) begin
          span = $urandom_range(10, 80);
          case ($urandom_range(0, 3))
            0:       ready_pct = 100;
            1:       ready_pct = 70;
            2:       ready_pct = 40;
            default: ready_pct = 15;
          endcase
        end
        span--;
        out_ready <= ($urandom_range(1, 100) <= ready_pct);
        @(posedge clk);
      end
    end
  end

  // Abort a hung run
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("testbench failed");
    $finish;
  end

  initial begin : stimulus
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    op          <= OP_LOAD;
    symbol      <= '0;
    code_bits   <= '0;
    code_length <= '0;
    hold_req    <= 1'b0;
    burst_left   = 0;
    n_load       = 0;
    n_encode     = 0;
    n_flush      = 0;
    n_unused     = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // nothing loaded, nothing pending, unused opcode: no output
    offer(OP_ENCODE, 8'd5, 32'hFFFF_FFFF, 6'd63);
    offer(OP_FLUSH, 8'd0, 32'h0, 6'd0);
    offer(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
    // full-length, single-bit, masked, overlong, zero-length and all-zero codes
    offer(OP_LOAD, 8'd0, 32'hFFFF_FFFF, 6'd32);
    offer(OP_LOAD, 8'hFF, 32'hFFFF_FFFF, 6'd1);
    offer(OP_LOAD, 8'd1, 32'hFFFF_FFFF, 6'd3);
    offer(OP_LOAD, 8'd2, 32'hA5C3_0F96, 6'd63);
    offer(OP_LOAD, 8'd3, 32'h0001_2345, 6'd0);
    offer(OP_LOAD, 8'd4, 32'h0000_0000, 6'd5);
    // zero byte encodes normally; a 32-bit code on top of one pending bit
    offer(OP_ENCODE, 8'd0, 32'h0, 6'd0);
    offer(OP_ENCODE, 8'hFF, 32'h0, 6'd0);
    offer(OP_ENCODE, 8'd2, 32'h0, 6'd0);
    offer(OP_ENCODE, 8'd3, 32'h0, 6'd0);
    offer(OP_FLUSH, 8'd0, 32'h0, 6'd0);
    offer(OP_FLUSH, 8'd0, 32'h0, 6'd0);
    offer(OP_ENCODE, 8'd1, 32'h0, 6'd0);
    offer(OP_ENCODE, 8'd4, 32'h0, 6'd0);
    offer(OP_ENCODE, 8'd1, 32'h0, 6'd0);
    offer(OP_FLUSH, 8'd0, 32'h0, 6'd0);
    // clearing an entry stops its output
    offer(OP_LOAD, 8'd0, 32'h0000_1234, 6'd0);
    offer(OP_ENCODE, 8'd0, 32'h0, 6'd0);
    offer(OP_LOAD, 8'd0, 32'h0000_005A, 6'd7);

    // fill the symbol pool, then mix operations
    for (int s = 0; s < POOL_SIZE; s++)
      offer(OP_LOAD, SYM_W'(s), $urandom, LEN_W'($urandom_range(1, 16)));
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == HOLD_AT) hold_req <= 1'b1;
      if (i == DRAIN_AT) drain();
      random_item();
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d loads, %0d encodes, %0d flushes and %0d unused opcodes",
             n_load, n_encode, n_flush, n_unused);
    $display("compared %0d coded bytes across a %0d-cycle output hold and a full drain",
             bytes_checked, LONG_HOLD);
    if (fail_count == 0 && bytes_due == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
